// ----- rtl/sipq_pkg.sv -----
// shared types and constants of the sorted-insert priority queue
package sipq_pkg;

    localparam int CAPACITY = 128;
    localparam int COUNT_W  = $clog2(CAPACITY + 1);

    localparam int DATA_W   = 32;
    localparam int S_DATA_W = 64;
    localparam int M_DATA_W = 144;

    localparam logic       REQ_ENQUEUE = 1'b0;
    localparam logic       REQ_DEQUEUE = 1'b1;

    localparam logic [1:0] STATUS_DONE  = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic signed [DATA_W-1:0] priority_num;
        logic signed [DATA_W-1:0] value;
    } entry_t;

    // broadcast to every cell of the row
    typedef struct packed {
        logic   enable;
        logic   dequeue;
        entry_t new_entry;
    } cell_ctl_t;

endpackage

// ----- rtl/sipq_cell.sv -----
// one slot of the sorted shift row: compare, hold, or take from a neighbour
module sipq_cell (
    input  logic               aclk,
    input  sipq_pkg::cell_ctl_t ctl,
    input  logic               occupied,
    input  sipq_pkg::entry_t   left_entry,
    input  logic               left_ins,
    input  sipq_pkg::entry_t   right_entry,
    output logic               ins,
    output sipq_pkg::entry_t   entry,
    output sipq_pkg::entry_t   entry_next
);

    sipq_pkg::entry_t entry_reg;

    // new entry belongs at or before this slot
    assign ins = !occupied || (entry_reg.priority_num > ctl.new_entry.priority_num);

    always_comb begin
        entry_next = entry_reg;
        if (ctl.enable) begin
            if (ctl.dequeue) begin
                entry_next = right_entry;
            end else if (ins) begin
                entry_next = left_ins ? left_entry : ctl.new_entry;
            end
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ----- rtl/sorted_insert_priority_queue.sv -----
// top level: sorted-insert priority queue built as a row of compare-and-shift cells
//
//  channel | dir | tdata (low bit up)                                  | tuser
//  s_      | in  | in_value[31:0], in_priority[63:32]                  | req_type
//  m_      | out | removed_value, removed_priority, head_value,       | status[1:0]
//          |     | head_priority, entry_count, is_empty, is_full, pad  |
//
// one request per cycle while s_tready is high: every cell compares against the new priority and
// shifts in the same cycle, so the row of cells sets the whole step
// the result beat sits in an output register; a new request is taken while
// that register is empty or being drained in the same cycle
// reset clears the entry count and the output valid; slot contents need no reset
// a stalled result holds its beat and holds back s_tready
module sorted_insert_priority_queue (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [sipq_pkg::S_DATA_W-1:0] s_tdata,  // in_value, in_priority
    input  logic                          s_tuser,  // req_type
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [sipq_pkg::M_DATA_W-1:0] m_tdata,  // removed_value, removed_priority,
                                                    // head_value, head_priority,
                                                    // entry_count, is_empty, is_full
    output logic [1:0]                    m_tuser   // status
);

    localparam int CAP = sipq_pkg::CAPACITY;
    localparam int CW  = sipq_pkg::COUNT_W;

    logic [CW-1:0]                  count_reg, count_next;
    logic                           m_valid_reg;
    logic [sipq_pkg::M_DATA_W-1:0]  m_data_reg, m_data_next;
    logic [1:0]                     m_user_reg, m_user_next;

    logic                 accept;
    logic                 is_full_now, is_empty_now;
    logic                 enq_ok, deq_ok;
    sipq_pkg::cell_ctl_t  ctl;

    // per-cell wiring along the row
    sipq_pkg::entry_t cell_entry      [CAP];
    sipq_pkg::entry_t cell_entry_next [CAP];
    logic             cell_ins        [CAP];

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign is_full_now  = (count_reg == CW'(CAP));
    assign is_empty_now = (count_reg == '0);
    assign enq_ok = accept && (s_tuser == sipq_pkg::REQ_ENQUEUE) && !is_full_now;
    assign deq_ok = accept && (s_tuser == sipq_pkg::REQ_DEQUEUE) && !is_empty_now;

    assign ctl.enable                 = enq_ok || deq_ok;
    assign ctl.dequeue                = (s_tuser == sipq_pkg::REQ_DEQUEUE);
    assign ctl.new_entry.value        = s_tdata[31:0];
    assign ctl.new_entry.priority_num = s_tdata[63:32];

    // the row: slot 0 is the head, entries shift right on insert and left on removal
    for (genvar i = 0; i < CAP; i++) begin : g_cell
        sipq_pkg::entry_t left_entry, right_entry;
        logic             left_ins;

        if (i == 0) begin : g_first
            assign left_entry = '0;
            assign left_ins   = 1'b0;
        end else begin : g_mid
            assign left_entry = cell_entry[i-1];
            assign left_ins   = cell_ins[i-1];
        end

        if (i == CAP - 1) begin : g_last
            assign right_entry = '0;
        end else begin : g_inner
            assign right_entry = cell_entry[i+1];
        end

        sipq_cell u_cell (
            .aclk        (aclk),
            .ctl         (ctl),
            .occupied    (count_reg > CW'(i)),
            .left_entry  (left_entry),
            .left_ins    (left_ins),
            .right_entry (right_entry),
            .ins         (cell_ins[i]),
            .entry       (cell_entry[i]),
            .entry_next  (cell_entry_next[i])
        );
    end

    always_comb begin
        count_next = count_reg;
        if (enq_ok) begin
            count_next = count_reg + CW'(1);
        end else if (deq_ok) begin
            count_next = count_reg - CW'(1);
        end
    end

    // result beat: the removed entry, with head and count from the state after the step
    always_comb begin
        logic [CW+7:0]    count_wide;
        sipq_pkg::entry_t removed, head;

        count_wide = {8'd0, count_next};
        removed    = deq_ok ? cell_entry[0] : '0;
        head       = (count_next != '0) ? cell_entry_next[0] : '0;

        m_data_next = {6'd0,
                       (count_next == CW'(CAP)),
                       (count_next == '0),
                       count_wide[7:0],
                       head.priority_num,
                       head.value,
                       removed.priority_num,
                       removed.value};

        if (s_tuser == sipq_pkg::REQ_ENQUEUE && is_full_now) begin
            m_user_next = sipq_pkg::STATUS_FULL;
        end else if (s_tuser == sipq_pkg::REQ_DEQUEUE && is_empty_now) begin
            m_user_next = sipq_pkg::STATUS_EMPTY;
        end else begin
            m_user_next = sipq_pkg::STATUS_DONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload needs no reset
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= m_data_next;
            m_user_reg <= m_user_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule
